// File: rtl/core/spiral_disc_window_generator_core_defines.svh
// Assertion macros shared by the core's modules.
`ifndef SPIRAL_DISC_WINDOW_GENERATOR_CORE_DEFINES_SVH
`define SPIRAL_DISC_WINDOW_GENERATOR_CORE_DEFINES_SVH

// Checks an implication on every rising clock edge outside reset.
`define SDWG_ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define SDWG_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/sdwg_pkg.sv
package sdwg_pkg;

    localparam int COORD_BITS = 16;
    localparam int RADIUS_BITS = 3;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 3'd4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_z;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] tile_x;
        logic signed [COORD_BITS-1:0] tile_z;
        logic                         is_last;
    } t_out_word;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef enum logic [2:0] {
        SEG_CENTER,
        SEG_TOP,
        SEG_RIGHT,
        SEG_BOTTOM,
        SEG_LEFT
    } t_seg;

    typedef struct packed {
        logic load;
        logic step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic cand_last;
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/core/spiral_disc_window_generator_core.sv
// Spiral disc window generator.
// Input channel (i_in_valid / o_in_stall) takes one word with a center tile.
// Output channel (o_out_valid / i_out_stall) returns every tile within the
// disc of the configured radius, center first, then ring by ring (top edge
// left to right, right edge down, bottom edge right to left, left edge up).
// The last word of a request has is_last set.
// i_cfg_we writes the radius from i_cfg_wdata; values above MAX_RADIUS
// saturate. Write it only while no request is in flight.
// The input word is loaded into the walk registers; the first word is then
// registered in the output register when the center tile is tested. The
// walker tests one candidate per cycle while the walk is not held, and stops
// at the last tile. The walk holds while the output register is full and
// stalled; a new request is taken as soon as the walk of the previous one
// has finished, even if its last word still waits.
// Reset (synchronous, active low) empties the output, returns to idle and
// sets the radius to 4.
module spiral_disc_window_generator_core #(
    parameter int MAX_RADIUS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  sdwg_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output sdwg_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_we,
    input  logic [sdwg_pkg::RADIUS_BITS-1:0]  i_cfg_wdata
);

    logic [sdwg_pkg::RADIUS_BITS-1:0] r_view_radius;
    sdwg_pkg::t_ctrl_cmd              cmd;
    sdwg_pkg::t_dp_status             status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_radius <= sdwg_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_view_radius <= i_cfg_wdata;
        end
    end

    sdwg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sdwg_dp #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_in_word     (i_in_word),
        .i_view_radius (r_view_radius),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word)
    );

endmodule

// File: rtl/core/sdwg_ctrl.sv
`include "spiral_disc_window_generator_core_defines.svh"

module sdwg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sdwg_pkg::t_dp_status  i_status,
    output sdwg_pkg::t_ctrl_cmd   o_cmd
);

    sdwg_pkg::t_state r_state;
    sdwg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdwg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            sdwg_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sdwg_pkg::ST_WALK;
                end
            end
            sdwg_pkg::ST_WALK: begin
                // A candidate is only tested when the output register can take it.
                o_cmd.step = i_status.out_free;
                if (i_status.out_free && i_status.cand_last) begin
                    n_state = sdwg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sdwg_pkg::ST_IDLE;
            end
        endcase
    end

    `SDWG_ASSERT_IMPL(a_load_starts_walk, o_cmd.load |=> (r_state == sdwg_pkg::ST_WALK), "load did not start a walk")
    `SDWG_ASSERT_IMPL(a_last_ends_walk, (o_cmd.step && i_status.cand_last) |=> (r_state == sdwg_pkg::ST_IDLE), "walk did not end after the last tile")

endmodule

// File: rtl/core/sdwg_dp.sv
`include "spiral_disc_window_generator_core_defines.svh"

module sdwg_dp #(
    parameter int MAX_RADIUS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sdwg_pkg::t_ctrl_cmd                  i_cmd,
    output sdwg_pkg::t_dp_status                 o_status,
    input  sdwg_pkg::t_in_word                   i_in_word,
    input  logic [sdwg_pkg::RADIUS_BITS-1:0]     i_view_radius,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output sdwg_pkg::t_out_word                  o_out_word
);

    localparam int RAD_W = $clog2(MAX_RADIUS + 1);
    localparam int OFS_W = RAD_W + 1;
    localparam int SQ_W  = 2 * OFS_W;

    logic signed [sdwg_pkg::COORD_BITS-1:0] r_cx;
    logic signed [sdwg_pkg::COORD_BITS-1:0] r_cz;
    logic [RAD_W-1:0]                       r_rad;
    logic [2*RAD_W-1:0]                     r_rad2;
    logic signed [OFS_W-1:0]                r_dx;
    logic signed [OFS_W-1:0]                r_dz;
    logic signed [OFS_W-1:0]                r_ring;
    sdwg_pkg::t_seg                         r_seg;
    sdwg_pkg::t_out_word                    r_out;
    logic                                   r_out_valid;

    logic signed [OFS_W-1:0]                n_dx;
    logic signed [OFS_W-1:0]                n_dz;
    logic signed [OFS_W-1:0]                n_ring;
    sdwg_pkg::t_seg                         n_seg;

    logic [RAD_W-1:0]                       rad_sat;
    logic signed [OFS_W-1:0]                ofs_rad;
    logic signed [SQ_W-1:0]                 dx_sq;
    logic signed [SQ_W-1:0]                 dz_sq;
    logic [SQ_W:0]                          dist2;
    logic                                   cand_inside;
    logic                                   cand_last;
    logic                                   out_free;

    // Radius values above the supported maximum saturate.
    assign rad_sat = (i_view_radius > sdwg_pkg::RADIUS_BITS'(MAX_RADIUS))
                   ? RAD_W'(MAX_RADIUS) : i_view_radius[RAD_W-1:0];

    assign ofs_rad     = signed'({1'b0, r_rad});
    assign dx_sq       = r_dx * r_dx;
    assign dz_sq       = r_dz * r_dz;
    assign dist2       = {1'b0, dx_sq} + {1'b0, dz_sq};
    assign cand_inside = dist2 <= (SQ_W + 1)'(r_rad2);
    // On the outer ring only the four axis points lie in the disc, so the
    // left axis point is always the final tile.
    assign cand_last   = (r_dx == -ofs_rad) && (r_dz == '0);
    assign out_free    = !r_out_valid || !i_out_stall;

    assign o_status.cand_last = cand_last;
    assign o_status.out_free  = out_free;

    // Spiral walk: center, then per ring top, right, bottom and left edges.
    always_comb begin
        n_dx   = r_dx;
        n_dz   = r_dz;
        n_ring = r_ring;
        n_seg  = r_seg;
        case (r_seg)
            sdwg_pkg::SEG_CENTER: begin
                n_ring = OFS_W'(1);
                n_seg  = sdwg_pkg::SEG_TOP;
                n_dx   = -OFS_W'(1);
                n_dz   = OFS_W'(1);
            end
            sdwg_pkg::SEG_TOP: begin
                if (r_dx == r_ring) begin
                    n_seg = sdwg_pkg::SEG_RIGHT;
                    n_dz  = r_ring - OFS_W'(1);
                end else begin
                    n_dx = r_dx + OFS_W'(1);
                end
            end
            sdwg_pkg::SEG_RIGHT: begin
                if (r_dz == -r_ring) begin
                    n_seg = sdwg_pkg::SEG_BOTTOM;
                    n_dx  = r_ring - OFS_W'(1);
                end else begin
                    n_dz = r_dz - OFS_W'(1);
                end
            end
            sdwg_pkg::SEG_BOTTOM: begin
                if (r_dx == -r_ring) begin
                    n_seg = sdwg_pkg::SEG_LEFT;
                    n_dz  = -r_ring + OFS_W'(1);
                end else begin
                    n_dx = r_dx - OFS_W'(1);
                end
            end
            sdwg_pkg::SEG_LEFT: begin
                if (r_dz == r_ring - OFS_W'(1)) begin
                    n_ring = r_ring + OFS_W'(1);
                    n_seg  = sdwg_pkg::SEG_TOP;
                    n_dx   = -(r_ring + OFS_W'(1));
                    n_dz   = r_ring + OFS_W'(1);
                end else begin
                    n_dz = r_dz + OFS_W'(1);
                end
            end
            default: begin
                n_seg = sdwg_pkg::SEG_CENTER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx   <= i_in_word.center_x;
            r_cz   <= i_in_word.center_z;
            r_rad  <= rad_sat;
            r_rad2 <= rad_sat * rad_sat;
            r_dx   <= '0;
            r_dz   <= '0;
            r_ring <= '0;
            r_seg  <= sdwg_pkg::SEG_CENTER;
        end else if (i_cmd.step) begin
            r_dx   <= n_dx;
            r_dz   <= n_dz;
            r_ring <= n_ring;
            r_seg  <= n_seg;
        end
        if (i_cmd.step && cand_inside) begin
            r_out.tile_x  <= r_cx + sdwg_pkg::COORD_BITS'(r_dx);
            r_out.tile_z  <= r_cz + sdwg_pkg::COORD_BITS'(r_dz);
            r_out.is_last <= cand_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && cand_inside) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `SDWG_ASSERT_IMPL(a_last_emitted, (i_cmd.step && cand_last) |=> (r_out_valid && r_out.is_last), "final tile was not emitted")
    `SDWG_ASSERT_IMPL(a_load_at_center, i_cmd.load |=> ((r_dx == '0) && (r_dz == '0)), "walk did not start at the center")

endmodule
